// ----- hdl/bbpe_pkg.sv -----
// shared types, constants and rounding helpers for the bezier patch evaluator
package bbpe_pkg;

   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
   localparam int COORD_W         = 32;
   localparam int WFRAC           = 30;
   localparam int W_W             = WFRAC + 1;
   localparam int W3_W            = W_W + 2;
   localparam int ACC_W           = 64;
   localparam int RND_W           = ACC_W - WFRAC;
   localparam int ROW_W           = COORD_W + 1;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     operation;
      logic [1:0]                 point_row;
      logic [1:0]                 point_col;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
      logic [PARAM_W-1:0]         param_u;
      logic [PARAM_W-1:0]         param_v;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  surface_x;
      logic signed [COORD_W-1:0]  surface_y;
      logic signed [COORD_W-1:0]  surface_z;
      logic                       saturated;
   } rsp_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   typedef logic [W_W-1:0] weight_type;
   typedef weight_type [3:0] weight_vec_type;

   // unsigned q0.30 product back to q0.30, round half up
   function automatic logic [W_W-1:0] rnd_u(input logic [ACC_W-1:0] p);
      logic [ACC_W-1:0] s;
      s = p + (ACC_W'(1) << (WFRAC - 1));
      return s[WFRAC +: W_W];
   endfunction

   // signed blend sum back to coordinate format, floor after adding half
   function automatic logic signed [RND_W-1:0] srnd(input logic signed [ACC_W-1:0] a);
      logic [ACC_W-1:0] b;
      b = a + (ACC_W'(1) << (WFRAC - 1));
      return b[WFRAC +: RND_W];
   endfunction

endpackage

// ----- hdl/bbpe_weights.sv -----
// three-stage cubic bernstein weight generator for one surface parameter
module bbpe_weights (
   input  logic                          clock,
   input  bbpe_pkg::stage_en_type        en,
   input  logic [bbpe_pkg::PARAM_W-1:0]  param,
   output bbpe_pkg::weight_vec_type      weight
);

   localparam logic [bbpe_pkg::PARAM_W-1:0] P_ONE =
      bbpe_pkg::PARAM_W'(1) << bbpe_pkg::PARAM_FRAC_BITS;
   localparam logic [bbpe_pkg::W_W-1:0] W_ONE =
      bbpe_pkg::W_W'(1) << bbpe_pkg::WFRAC;

   logic [bbpe_pkg::PARAM_W-1:0] tc;
   logic [bbpe_pkg::W_W-1:0]     tt_in, ss_in;
   logic [bbpe_pkg::W3_W-1:0]    tt3_in, ss3_in;

   logic [bbpe_pkg::W_W-1:0]     tt1_ff, ss1_ff, tt2_ff, ss2_ff;
   logic [bbpe_pkg::W3_W-1:0]    tt31_ff, ss31_ff, tt32_ff, ss32_ff;
   logic [bbpe_pkg::W_W-1:0]     sqs_ff, sqt_ff, sqs_in, sqt_in;
   bbpe_pkg::weight_vec_type     w_ff, w_in;

   // stage 1: clamp to one, move to q0.30, form t, 1-t and their triples
   always_comb begin
      tc     = (param > P_ONE) ? P_ONE : param;
      tt_in  = bbpe_pkg::W_W'(tc) << (bbpe_pkg::WFRAC - bbpe_pkg::PARAM_FRAC_BITS);
      ss_in  = W_ONE - tt_in;
      tt3_in = (bbpe_pkg::W3_W'(tt_in) << 1) + bbpe_pkg::W3_W'(tt_in);
      ss3_in = (bbpe_pkg::W3_W'(ss_in) << 1) + bbpe_pkg::W3_W'(ss_in);
   end

   // stage 2: squares
   always_comb begin
      sqs_in = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(ss1_ff) * bbpe_pkg::ACC_W'(ss1_ff));
      sqt_in = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(tt1_ff) * bbpe_pkg::ACC_W'(tt1_ff));
   end

   // stage 3: cubic weights
   always_comb begin
      w_in[0] = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(sqs_ff) * bbpe_pkg::ACC_W'(ss2_ff));
      w_in[1] = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(sqs_ff) * bbpe_pkg::ACC_W'(tt32_ff));
      w_in[2] = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(sqt_ff) * bbpe_pkg::ACC_W'(ss32_ff));
      w_in[3] = bbpe_pkg::rnd_u(bbpe_pkg::ACC_W'(sqt_ff) * bbpe_pkg::ACC_W'(tt2_ff));
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         tt1_ff  <= tt_in;
         ss1_ff  <= ss_in;
         tt31_ff <= tt3_in;
         ss31_ff <= ss3_in;
      end
      if (en.s2) begin
         sqs_ff  <= sqs_in;
         sqt_ff  <= sqt_in;
         tt2_ff  <= tt1_ff;
         ss2_ff  <= ss1_ff;
         tt32_ff <= tt31_ff;
         ss32_ff <= ss31_ff;
      end
      if (en.s3) begin
         w_ff <= w_in;
      end
   end

   assign weight = w_ff;

endmodule

// ----- hdl/bicubic_bezier_patch_eval_core.sv -----
// top level: bicubic bezier patch store and eight-stage evaluation pipeline
// throughput: one beat per cycle, every stage moves on in each cycle the result side takes
// a load beat writes the control point store as it leaves stage 3 and gives no result
// reset clears only the stage valid bits and holds req_ready low; the store is not cleared
// and an evaluate must not read a point that was never loaded
module bicubic_bezier_patch_eval_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbpe_pkg::rsp_type rsp_data
);

   localparam int STAGES = 8;

   // load/opcode payload that travels with the weight stages
   typedef struct packed {
      bbpe_pkg::op_type                             op;
      logic [1:0]                                   row;
      logic [1:0]                                   col;
      logic [2:0][bbpe_pkg::COORD_W-1:0]            crd;
   } ld_type;

   // per-stage valid bits and ready chain (bubbles collapse on a stall)
   logic [STAGES:1] vld_ff, vld_in, rdy;

   ld_type ld1_ff, ld2_ff, ld3_ff, ld1_in;

   bbpe_pkg::stage_en_type   wen;
   bbpe_pkg::weight_vec_type wu3, wv3, wv4_ff, wv5_ff;

   // control point store, coordinate / row / column, no reset
   logic signed [bbpe_pkg::COORD_W-1:0] ctrl_ff [0:2][0:3][0:3];

   // stage 4: u products, stage 5: row blends
   logic signed [bbpe_pkg::ACC_W-1:0] prod_ff [0:2][0:3][0:3];
   logic signed [bbpe_pkg::ACC_W-1:0] prod_in [0:2][0:3][0:3];
   logic signed [bbpe_pkg::ROW_W-1:0] row_ff  [0:2][0:3];
   logic signed [bbpe_pkg::ROW_W-1:0] row_in  [0:2][0:3];

   // stage 6: v products, stage 7: final blends before clipping
   logic signed [bbpe_pkg::ACC_W-1:0] vprod_ff [0:2][0:3];
   logic signed [bbpe_pkg::ACC_W-1:0] vprod_in [0:2][0:3];
   logic signed [bbpe_pkg::RND_W-1:0] fin_ff   [0:2];
   logic signed [bbpe_pkg::RND_W-1:0] fin_in   [0:2];

   // stage 8: output register
   bbpe_pkg::rsp_type rsp_ff, rsp_in;

   logic [2:0]                         sat_bits;
   logic [2:0][bbpe_pkg::COORD_W-1:0]  clip_val;
   logic [bbpe_pkg::RND_W-bbpe_pkg::COORD_W:0] hi_bits;

   // ready chain from the output back to the input
   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   // no beat is taken while reset is high
   assign req_ready = rdy[1] && !reset;

   // valid bits follow their data; loads drop out once they write the store
   always_comb begin
      vld_in[1] = req_valid;
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      vld_in[4] = vld_ff[3] && (ld3_ff.op == bbpe_pkg::OP_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // weight generators, aligned with stages 1 to 3
   assign wen.s1 = rdy[1];
   assign wen.s2 = rdy[2];
   assign wen.s3 = rdy[3];

   bbpe_weights u_wgt_u (
      .clock  (clock),
      .en     (wen),
      .param  (req_data.param_u),
      .weight (wu3)
   );

   bbpe_weights u_wgt_v (
      .clock  (clock),
      .en     (wen),
      .param  (req_data.param_v),
      .weight (wv3)
   );

   always_comb begin
      ld1_in.op  = req_data.operation;
      ld1_in.row = req_data.point_row;
      ld1_in.col = req_data.point_col;
      ld1_in.crd = {req_data.coord_z, req_data.coord_y, req_data.coord_x};
   end

   // u products: every stored point feeds its own multiplier
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
               prod_in[c][r][k] =
                  bbpe_pkg::ACC_W'($signed({1'b0, wu3[k]})) *
                  bbpe_pkg::ACC_W'(ctrl_ff[c][r][k]);
            end
         end
      end
   end

   // row blends keep one extra bit of range, no saturation here
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 4; r++) begin
            row_in[c][r] = bbpe_pkg::ROW_W'(bbpe_pkg::srnd(
               prod_ff[c][r][0] + prod_ff[c][r][1] +
               prod_ff[c][r][2] + prod_ff[c][r][3]));
         end
      end
   end

   // v products and final blend
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 4; r++) begin
            vprod_in[c][r] =
               bbpe_pkg::ACC_W'($signed({1'b0, wv5_ff[r]})) *
               bbpe_pkg::ACC_W'(row_ff[c][r]);
         end
         fin_in[c] = bbpe_pkg::srnd(vprod_ff[c][0] + vprod_ff[c][1] +
                                    vprod_ff[c][2] + vprod_ff[c][3]);
      end
   end

   // clip to the 32-bit range: in range when the top bits are all equal
   always_comb begin
      hi_bits = '0;
      for (int c = 0; c < 3; c++) begin
         hi_bits     = fin_ff[c][bbpe_pkg::RND_W-1:bbpe_pkg::COORD_W-1];
         sat_bits[c] = !((&hi_bits) || !(|hi_bits));
         if (!sat_bits[c]) begin
            clip_val[c] = fin_ff[c][bbpe_pkg::COORD_W-1:0];
         end else if (fin_ff[c][bbpe_pkg::RND_W-1]) begin
            clip_val[c] = {1'b1, {(bbpe_pkg::COORD_W-1){1'b0}}};
         end else begin
            clip_val[c] = {1'b0, {(bbpe_pkg::COORD_W-1){1'b1}}};
         end
      end
      rsp_in.surface_x = clip_val[0];
      rsp_in.surface_y = clip_val[1];
      rsp_in.surface_z = clip_val[2];
      rsp_in.saturated = |sat_bits;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ld1_ff <= ld1_in;
      end
      if (rdy[2]) begin
         ld2_ff <= ld1_ff;
      end
      if (rdy[3]) begin
         ld3_ff <= ld2_ff;
      end
      // a load writes the store as it leaves stage 3, where evaluates read it
      if (vld_ff[3] && rdy[4] && (ld3_ff.op == bbpe_pkg::OP_LOAD)) begin
         for (int c = 0; c < 3; c++) begin
            ctrl_ff[c][ld3_ff.row][ld3_ff.col] <= ld3_ff.crd[c];
         end
      end
      if (rdy[4]) begin
         prod_ff <= prod_in;
         wv4_ff  <= wv3;
      end
      if (rdy[5]) begin
         row_ff <= row_in;
         wv5_ff <= wv4_ff;
      end
      if (rdy[6]) begin
         vprod_ff <= vprod_in;
      end
      if (rdy[7]) begin
         fin_ff <= fin_in;
      end
      if (rdy[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[STAGES];
   assign rsp_data  = rsp_ff;

endmodule

// ----- tb/sv/bicubic_bezier_patch_eval_core_tb.sv -----
// self-checking testbench for the bicubic bezier patch evaluator core
`timescale 1ns / 1ps

module bicubic_bezier_patch_eval_core_tb;

   localparam int     HALF_PERIOD  = 5;
   localparam int     RESET_CYCLES = 4;
   localparam int     QUIET_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int     DRAIN_TAIL   = 20;    // idle time beyond the pipeline drain
   localparam int     IDLE_PCT     = 25;
   localparam int     RSP_HOLD     = 80;    // long receiver hold-off
   localparam int     HOLD_AT      = 120;   // results seen before the hold-off starts
   localparam int     BERN_SCALE   = 3;     // factor of the two middle bernstein weights
   localparam longint COORD_MAX    = 64'sd2147483647;
   localparam longint COORD_MIN    = -64'sd2147483648;
   localparam int     PARAM_ONE    = 1 << bbpe_pkg::PARAM_FRAC_BITS;
   localparam int     PARAM_TOP    = (1 << bbpe_pkg::PARAM_W) - 1;

   typedef logic [3:0][31:0] bern_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bbpe_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bbpe_pkg::rsp_type rsp_data;

   bicubic_bezier_patch_eval_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // stimulus waiting for the driver, and surface points still owed by the block
   bbpe_pkg::req_type pending_reqs [$];
   bbpe_pkg::rsp_type surface_q [$];

   // predictor copy of the control point store, [axis][row*4+col]
   logic signed [31:0] patch_pt [3][16];

   int  err_count      = 0;
   int  beats_offered  = 0;
   int  loads_taken    = 0;
   int  evals_taken    = 0;
   int  results_seen   = 0;
   int  sat_seen       = 0;
   int  quiet_cycles   = 0;
   int  stall_left     = 0;
   bit  stall_used     = 1'b0;
   bit  req_taken      = 1'b0;

   initial begin
      for (int a = 0; a < 3; a++)
         for (int i = 0; i < 16; i++)
            patch_pt[a][i] = '0;
   end

   // ---------------------------------------------------------------- predictor

   // unsigned q0.30 product back to q0.30, round half up
   function automatic logic [63:0] round_q30u(input logic [63:0] p);
      return (p + (64'd1 << (bbpe_pkg::WFRAC - 1))) >> bbpe_pkg::WFRAC;
   endfunction

   // signed blend sum to coordinate format: floor after adding one half
   function automatic longint round_q30s(input longint a);
      return (a + (longint'(1) << (bbpe_pkg::WFRAC - 1))) >>> bbpe_pkg::WFRAC;
   endfunction

   // cubic bernstein weights in q0.30, parameter clamped to one
   function automatic bern_type bern_weights(input logic [bbpe_pkg::PARAM_W-1:0] raw);
      logic [63:0] t, big_t, big_s, s2, t2;
      bern_type    w;
      t = 64'(raw);
      if (t > 64'(PARAM_ONE))
         t = 64'(PARAM_ONE);
      big_t = t << (bbpe_pkg::WFRAC - bbpe_pkg::PARAM_FRAC_BITS);
      big_s = (64'd1 << bbpe_pkg::WFRAC) - big_t;
      s2    = round_q30u(big_s * big_s);
      t2    = round_q30u(big_t * big_t);
      w[0]  = 32'(round_q30u(s2 * big_s));
      w[1]  = 32'(round_q30u(64'(BERN_SCALE) * s2 * big_t));
      w[2]  = 32'(round_q30u(64'(BERN_SCALE) * t2 * big_s));
      w[3]  = 32'(round_q30u(t2 * big_t));
      return w;
   endfunction

   // rows blended by u, then the row results blended by v, no saturation inside
   function automatic longint blend_axis(input int axis, input bern_type wu,
                                         input bern_type wv);
      longint rows [4];
      longint acc;
      for (int r = 0; r < 4; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++)
            acc += longint'(wu[c]) * longint'(patch_pt[axis][r*4 + c]);
         rows[r] = round_q30s(acc);
      end
      acc = 0;
      for (int r = 0; r < 4; r++)
         acc += longint'(wv[r]) * rows[r];
      return round_q30s(acc);
   endfunction

   function automatic bbpe_pkg::rsp_type predict_surface(input bbpe_pkg::req_type item);
      bern_type          wu, wv;
      longint            v;
      logic [31:0]       pt [3];
      bbpe_pkg::rsp_type res;
      wu  = bern_weights(item.param_u);
      wv  = bern_weights(item.param_v);
      res = '0;
      for (int a = 0; a < 3; a++) begin
         v = blend_axis(a, wu, wv);
         if (v > COORD_MAX) begin
            v = COORD_MAX;
            res.saturated = 1'b1;
         end else if (v < COORD_MIN) begin
            v = COORD_MIN;
            res.saturated = 1'b1;
         end
         pt[a] = 32'(v);
      end
      res.surface_x = pt[0];
      res.surface_y = pt[1];
      res.surface_z = pt[2];
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      err_count++;
   endtask

   // beats on both channels are sampled at the rising edge
   always @(posedge clock) begin : watch_beats
      bbpe_pkg::rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_data.operation == bbpe_pkg::OP_LOAD) begin
               patch_pt[0][{req_data.point_row, req_data.point_col}] = req_data.coord_x;
               patch_pt[1][{req_data.point_row, req_data.point_col}] = req_data.coord_y;
               patch_pt[2][{req_data.point_row, req_data.point_col}] = req_data.coord_z;
               loads_taken++;
            end else begin
               surface_q.push_back(predict_surface(req_data));
               evals_taken++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.saturated === 1'b1)
               sat_seen++;
            if (surface_q.size() == 0) begin
               flag_mismatch("result beat with nothing owed", rsp_data.surface_x, 'x);
            end else begin
               want = surface_q.pop_front();
               if (rsp_data.surface_x !== want.surface_x)
                  flag_mismatch("surface_x", rsp_data.surface_x, want.surface_x);
               if (rsp_data.surface_y !== want.surface_y)
                  flag_mismatch("surface_y", rsp_data.surface_y, want.surface_y);
               if (rsp_data.surface_z !== want.surface_z)
                  flag_mismatch("surface_z", rsp_data.surface_z, want.surface_z);
               if (rsp_data.saturated !== want.saturated)
                  flag_mismatch("saturated", 32'(rsp_data.saturated), 32'(want.saturated));
            end
         end
      end
   end

   // watchdog on cycles with no beat anywhere
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // request side: a beat stays put until taken, gaps only between beats
   always @(negedge clock) begin : drive_req
      bit calm;
      calm = (beats_offered >= 350) && (beats_offered < 470);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            beats_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls, one long hold-off, one stretch always ready
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_used && results_seen >= HOLD_AT) begin
         stall_used <= 1'b1;
         stall_left <= RSP_HOLD - 1;
         rsp_ready  <= 1'b0;
      end else if (results_seen >= 230 && results_seen < 320) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic bbpe_pkg::req_type make_load(input int idx, input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] z);
      bbpe_pkg::req_type item;
      item.operation = bbpe_pkg::OP_LOAD;
      item.point_row = idx[3:2];
      item.point_col = idx[1:0];
      item.coord_x   = x;
      item.coord_y   = y;
      item.coord_z   = z;
      // parameters are ignored on a load, so they carry noise
      item.param_u   = bbpe_pkg::PARAM_W'($urandom_range(0, PARAM_TOP));
      item.param_v   = bbpe_pkg::PARAM_W'($urandom_range(0, PARAM_TOP));
      return item;
   endfunction

   function automatic bbpe_pkg::req_type make_eval(input int u, input int v);
      bbpe_pkg::req_type item;
      item.operation = bbpe_pkg::OP_EVAL;
      item.point_row = 2'($urandom);
      item.point_col = 2'($urandom);
      item.coord_x   = $urandom;
      item.coord_y   = $urandom;
      item.coord_z   = $urandom;
      item.param_u   = bbpe_pkg::PARAM_W'(u);
      item.param_v   = bbpe_pkg::PARAM_W'(v);
      return item;
   endfunction

   function automatic logic [31:0] edge_coord(input int k);
      case (k % 5)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_coord(input int style);
      case (style)
         0: return $urandom;
         1: return edge_coord($urandom_range(0, 4));
         default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      endcase
   endfunction

   // mostly inside [0, one], with the ends and the clamped range well visited
   function automatic int pick_param();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 0;
      else if (r < 16)
         return PARAM_ONE;
      else if (r < 26)
         return $urandom_range(PARAM_ONE + 1, PARAM_TOP);
      return $urandom_range(0, PARAM_ONE);
   endfunction

   task automatic push_directed();
      // whole patch loaded first so no evaluate ever reads an empty entry
      for (int i = 0; i < 16; i++)
         pending_reqs.push_back(make_load(i, edge_coord(i), edge_coord(i + 1),
                                          edge_coord(i + 2)));
      pending_reqs.push_back(make_eval(0, 0));
      pending_reqs.push_back(make_eval(PARAM_ONE, PARAM_ONE));
      pending_reqs.push_back(make_eval(0, PARAM_ONE));
      pending_reqs.push_back(make_eval(PARAM_ONE, 0));
      pending_reqs.push_back(make_eval(PARAM_ONE / 2, PARAM_ONE / 2));
      // parameter above one, clamped
      pending_reqs.push_back(make_eval(PARAM_TOP, PARAM_ONE + 1));
      pending_reqs.push_back(make_eval(1, PARAM_ONE - 1));
      pending_reqs.push_back(make_eval(PARAM_ONE - 1, 1));
   endtask

   // bursts of a patch update then a run of evaluations, with some noise beats
   task automatic push_random(input int n_items);
      int                count, style, nload, neval, idx;
      logic [31:0]       flat;
      bbpe_pkg::req_type item;
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            style = $urandom_range(0, 3);
            nload = (style == 3) ? 16 : $urandom_range(0, 16);
            flat  = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            for (int i = 0; i < nload; i++) begin
               idx = (nload == 16) ? i : $urandom_range(0, 15);
               // extreme patch, uniform in x and z, pushes rounding past the range
               if (style == 3)
                  item = make_load(idx, flat, pick_coord(1), flat);
               else
                  item = make_load(idx, pick_coord(style), pick_coord(style),
                                   pick_coord(style));
               pending_reqs.push_back(item);
            end
            neval = $urandom_range(1, 24);
            for (int i = 0; i < neval; i++)
               pending_reqs.push_back(make_eval(pick_param(), pick_param()));
            count += nload + neval;
         end else begin
            if ($urandom_range(0, 1))
               item = make_load($urandom_range(0, 15), $urandom, $urandom, $urandom);
            else
               item = make_eval($urandom_range(0, PARAM_TOP), $urandom_range(0, PARAM_TOP));
            pending_reqs.push_back(item);
            count++;
         end
      end
   endtask

   // sender holds back until every owed result has come out
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || surface_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin : run_test
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_directed();
      wait_drained();
      push_random(300);
      wait_drained();
      push_random(300);
      wait_drained();
      repeat (DRAIN_TAIL) @(negedge clock);

      $display("covered %0d control point loads and %0d evaluations, %0d results saturated",
               loads_taken, evals_taken, sat_seen);
      $display("with random gaps on both sides, a %0d-cycle result hold-off and drain pauses",
               RSP_HOLD);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/bbpe_pkg.sv
hdl/bbpe_weights.sv
hdl/bicubic_bezier_patch_eval_core.sv
tb/sv/bicubic_bezier_patch_eval_core_tb.sv
